@@ hdl/ncc_pkg.sv @@
// Shared types and constants for the nearest-centroid confusion counter.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package ncc_pkg;

    // Fixed field widths of the request and result items.
    localparam int CMD_W        = 2;
    localparam int CLASS_W      = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int NUM_CFG_REGS = 6;

    // Counter memory is addressed by {row, column}.
    localparam int MEM_ADDR_W = 2 * CLASS_W;
    localparam int MEM_DEPTH  = 1 << MEM_ADDR_W;

    // Result queue; deeper than the pipeline so a full rate can be kept.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLASSIFY = 2'd0,
        CMD_CLEAR    = 2'd1,
        CMD_READ     = 2'd2
    } ncc_cmd_t;

    // Control fields that travel alongside the distance pipeline.
    typedef struct packed {
        logic               vld;
        ncc_cmd_t           cmd;
        logic [CLASS_W-1:0] true_class;
        logic [CLASS_W-1:0] read_row;
        logic [CLASS_W-1:0] read_col;
    } ncc_ctl_t;

endpackage

`default_nettype wire

@@ hdl/nearest_centroid_confusion_counter_core.sv @@
// Top level of the nearest-centroid confusion counter: configuration,
// counter memory with read-modify-write, and the result queue.
// Depends on ncc_pkg and ncc_nearest.
`default_nettype none

// This block classifies 3-axis samples against NUM_CLASSES programmable
// centroids by exact squared Euclidean distance (lowest index wins a tie)
// and keeps a saturating confusion matrix of COUNT_BITS-wide counters, row
// by true class and column by predicted class. Each request on the s_axis
// side carries a command in tuser: classify-and-count, clear the matrix, or
// read one counter. Every request yields exactly one result on m_axis, in
// request order. The block takes one request per clock cycle for as long as
// the result side keeps up; a request passes through the four-stage distance
// pipeline, the counter memory's registered read and the write-back stage
// before its result enters the queue. Back-to-back updates to the same
// counter are handled by forwarding the just-written value, and a clear
// only drops the per-counter valid flags, so there is no clearing pass
// after reset. Results wait in an eight-entry queue; s_axis tready drops
// only when eight requests are outstanding, so a stall on the m_axis side
// never reaches s_axis combinationally. Centroid registers are written
// through the cfg port; the user must write them only while no request is
// in flight, as the block itself does not enforce it.
module nearest_centroid_confusion_counter_core
    import ncc_pkg::*;
#(
    parameter  int NUM_CLASSES = 6,
    parameter  int SAMPLE_BITS = 12,
    parameter  int COUNT_BITS  = 16,
    localparam int CENT_W      = 3 * SAMPLE_BITS,
    localparam int IN_W        = 3 * SAMPLE_BITS + 3 * CLASS_W,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W       = CLASS_W + COUNT_BITS,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Configuration write port.
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [CENT_W-1:0]      cfg_wdata,
    // Request channel.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata, low bit up: sample_x, sample_y, sample_z, true_class,
    // read_row, read_col, zero padding.
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: command.
    input  wire logic [CMD_W-1:0]       s_axis_tuser,
    // Result channel.
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata, low bit up: predicted_class, count_value, zero padding.
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam logic [CLASS_W:0]      NUM_CLASSES_W = (CLASS_W + 1)'(NUM_CLASSES);
    localparam logic [FIFO_PTR_W:0]   FIFO_FULL     = (FIFO_PTR_W + 1)'(FIFO_DEPTH);

    // ------------------------------------------------------------------
    // Centroid registers. Classes without a register keep a zero centre.
    // ------------------------------------------------------------------
    logic [NUM_CLASSES-1:0][CENT_W-1:0] centroid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centroid_reg <= '0;
        end else if (cfg_we) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                if (k < NUM_CFG_REGS && cfg_addr == CFG_IDX_W'(k)) begin
                    centroid_reg[k] <= cfg_wdata;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request unpacking and the distance pipeline.
    // ------------------------------------------------------------------
    logic     accept;
    ncc_ctl_t in_ctl;
    ncc_ctl_t m0_ctl;
    logic [CLASS_W-1:0] m0_pred;

    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_ctl.vld        = accept;
        in_ctl.cmd        = ncc_cmd_t'(s_axis_tuser);
        in_ctl.true_class = s_axis_tdata[3*SAMPLE_BITS +: CLASS_W];
        in_ctl.read_row   = s_axis_tdata[3*SAMPLE_BITS + CLASS_W +: CLASS_W];
        in_ctl.read_col   = s_axis_tdata[3*SAMPLE_BITS + 2*CLASS_W +: CLASS_W];
    end

    ncc_nearest #(
        .NUM_CLASSES (NUM_CLASSES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ncc_nearest (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (in_ctl),
        .in_x      (s_axis_tdata[0 +: SAMPLE_BITS]),
        .in_y      (s_axis_tdata[SAMPLE_BITS +: SAMPLE_BITS]),
        .in_z      (s_axis_tdata[2*SAMPLE_BITS +: SAMPLE_BITS]),
        .centroids (centroid_reg),
        .out_ctl   (m0_ctl),
        .out_pred  (m0_pred)
    );

    // ------------------------------------------------------------------
    // Memory read stage: pick the counter address and whether it exists.
    // ------------------------------------------------------------------
    logic [MEM_ADDR_W-1:0] m0_addr;
    logic                  m0_ok;

    always_comb begin
        if (m0_ctl.cmd == CMD_CLASSIFY) begin
            m0_addr = {m0_ctl.true_class, m0_pred};
            m0_ok   = {1'b0, m0_ctl.true_class} < NUM_CLASSES_W;
        end else begin
            m0_addr = {m0_ctl.read_row, m0_ctl.read_col};
            m0_ok   = ({1'b0, m0_ctl.read_row} < NUM_CLASSES_W)
                   && ({1'b0, m0_ctl.read_col} < NUM_CLASSES_W);
        end
    end

    // Counter storage. A counter whose valid flag is low reads as zero, so
    // a clear only has to drop the flags.
    logic [COUNT_BITS-1:0] cnt_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]  vbit_reg;

    logic                  m1_vld_reg;
    ncc_cmd_t              m1_cmd_reg;
    logic [MEM_ADDR_W-1:0] m1_addr_reg;
    logic [CLASS_W-1:0]    m1_pred_reg;
    logic                  m1_ok_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_vbit_reg;
    logic                  fwd_hit_reg, fwd_hit_next;
    logic [COUNT_BITS-1:0] fwd_data_reg, fwd_data_next;

    logic [COUNT_BITS-1:0] m1_cur;
    logic [COUNT_BITS-1:0] m1_inc;
    logic                  m1_we;
    logic                  m1_clr;
    logic [CLASS_W-1:0]    res_pred;
    logic [COUNT_BITS-1:0] res_count;

    always_ff @(posedge aclk) begin
        if (m1_we) begin
            cnt_mem[m1_addr_reg] <= m1_inc;
        end
        rd_data_reg <= cnt_mem[m0_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vbit_reg <= '0;
        end else if (m1_clr) begin
            vbit_reg <= '0;
        end else if (m1_we) begin
            vbit_reg[m1_addr_reg] <= 1'b1;
        end
    end

    // The request one stage ahead read the memory and the flags in the same
    // cycle that the write-back stage changed them, so it saw stale values.
    // Capture the new value of that counter (or zero after a clear) for it.
    assign fwd_hit_next  = m1_vld_reg && (m1_clr || (m1_we && m1_addr_reg == m0_addr));
    assign fwd_data_next = m1_we ? m1_inc : '0;

    always_ff @(posedge aclk) begin
        m1_cmd_reg   <= m0_ctl.cmd;
        m1_addr_reg  <= m0_addr;
        m1_pred_reg  <= m0_pred;
        m1_ok_reg    <= m0_ok;
        rd_vbit_reg  <= vbit_reg[m0_addr];
        fwd_data_reg <= fwd_data_next;
        if (!aresetn) begin
            m1_vld_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else begin
            m1_vld_reg  <= m0_ctl.vld;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    // ------------------------------------------------------------------
    // Write-back stage: saturating increment and result formation.
    // ------------------------------------------------------------------
    always_comb begin
        if (fwd_hit_reg) begin
            m1_cur = fwd_data_reg;
        end else if (rd_vbit_reg) begin
            m1_cur = rd_data_reg;
        end else begin
            m1_cur = '0;
        end
        m1_inc = (&m1_cur) ? m1_cur : m1_cur + 1'b1;

        m1_we     = 1'b0;
        m1_clr    = 1'b0;
        res_pred  = '0;
        res_count = '0;
        unique case (m1_cmd_reg)
            CMD_CLASSIFY: begin
                m1_we    = m1_vld_reg && m1_ok_reg;
                res_pred = m1_pred_reg;
                if (m1_ok_reg) begin
                    res_count = m1_inc;
                end
            end
            CMD_CLEAR: begin
                m1_clr = m1_vld_reg;
            end
            CMD_READ: begin
                if (m1_ok_reg) begin
                    res_count = m1_cur;
                end
            end
            default: begin
                // Unused command: no operation, an all-zero result.
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result queue and request credits. The credit count covers requests
    // in the pipeline plus results in the queue, so the queue never fills
    // past its depth.
    // ------------------------------------------------------------------
    logic [OUT_W-1:0]      fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_W:0]   fifo_cnt_reg, fifo_cnt_next;
    logic [FIFO_PTR_W:0]   credit_reg, credit_next;
    logic                  push;
    logic                  pop;

    assign push = m1_vld_reg;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= {res_count, res_pred};
        end
    end

    always_comb begin
        unique case ({push, pop})
            2'b10:   fifo_cnt_next = fifo_cnt_reg + 1'b1;
            2'b01:   fifo_cnt_next = fifo_cnt_reg - 1'b1;
            default: fifo_cnt_next = fifo_cnt_reg;
        endcase
        unique case ({accept, pop})
            2'b10:   credit_next = credit_reg + 1'b1;
            2'b01:   credit_next = credit_reg - 1'b1;
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            credit_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_next;
            credit_reg   <= credit_next;
        end
    end

    assign s_axis_tready = credit_reg < FIFO_FULL;
    assign m_axis_tvalid = fifo_cnt_reg != '0;
    assign m_axis_tdata  = OUT_TDATA_W'(fifo_mem[rd_ptr_reg]);

endmodule

`default_nettype wire

@@ hdl/ncc_nearest.sv @@
// Pipelined nearest-centroid search: squares, sums and an ordered compare.
// Depends on ncc_pkg for the control struct and class width.
`default_nettype none

module ncc_nearest
    import ncc_pkg::*;
#(
    parameter int NUM_CLASSES = 6,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire ncc_ctl_t                                   in_ctl,
    input  wire logic [SAMPLE_BITS-1:0]                     in_x,
    input  wire logic [SAMPLE_BITS-1:0]                     in_y,
    input  wire logic [SAMPLE_BITS-1:0]                     in_z,
    input  wire logic [NUM_CLASSES-1:0][3*SAMPLE_BITS-1:0]  centroids,
    output ncc_ctl_t                                        out_ctl,
    output logic [CLASS_W-1:0]                              out_pred
);

    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int DIST_W = SQ_W + 2;

    ncc_ctl_t                         s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg;
    logic [2:0][SAMPLE_BITS-1:0]      s1_smp_reg;
    logic [NUM_CLASSES-1:0][2:0][SQ_W-1:0] s2_sq_reg, s2_sq_next;
    logic [NUM_CLASSES-1:0][DIST_W-1:0]    s3_dist_reg, s3_dist_next;
    logic [CLASS_W-1:0]               s4_pred_reg, s4_pred_next;

    // Stage 1: register the sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
        end else begin
            s1_ctl_reg <= in_ctl;
        end
        s1_smp_reg <= {in_z, in_y, in_x};
    end

    // Stage 2: one absolute difference and one square per axis and class.
    always_comb begin
        logic [SAMPLE_BITS-1:0] a;
        logic [SAMPLE_BITS-1:0] c;
        logic [SAMPLE_BITS-1:0] d;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            for (int ax = 0; ax < 3; ax++) begin
                a = s1_smp_reg[ax];
                c = centroids[k][ax*SAMPLE_BITS +: SAMPLE_BITS];
                d = (a > c) ? (a - c) : (c - a);
                s2_sq_next[k][ax] = SQ_W'(d) * SQ_W'(d);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_ctl_reg <= '0;
        end else begin
            s2_ctl_reg <= s1_ctl_reg;
        end
        s2_sq_reg  <= s2_sq_next;
    end

    // Stage 3: exact squared distance to each centroid.
    always_comb begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
            s3_dist_next[k] = DIST_W'(s2_sq_reg[k][0]) + DIST_W'(s2_sq_reg[k][1])
                            + DIST_W'(s2_sq_reg[k][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_ctl_reg <= '0;
        end else begin
            s3_ctl_reg <= s2_ctl_reg;
        end
        s3_dist_reg <= s3_dist_next;
    end

    // Stage 4: ordered minimum search; a strict less-than keeps the lowest
    // index on a tie.
    always_comb begin
        logic [DIST_W-1:0] best_d;
        best_d       = s3_dist_reg[0];
        s4_pred_next = '0;
        for (int k = 1; k < NUM_CLASSES; k++) begin
            if (s3_dist_reg[k] < best_d) begin
                best_d       = s3_dist_reg[k];
                s4_pred_next = CLASS_W'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_ctl_reg <= '0;
        end else begin
            s4_ctl_reg <= s3_ctl_reg;
        end
        s4_pred_reg <= s4_pred_next;
    end

    assign out_ctl  = s4_ctl_reg;
    assign out_pred = s4_pred_reg;

endmodule

`default_nettype wire

@@ hdl/ncc_checker.sv @@
// Port-level assertions for the nearest-centroid confusion counter, and the
// bind that attaches them to the top level. Depends on ncc_pkg.
`default_nettype none

module ncc_checker
    import ncc_pkg::*;
#(
    parameter int NUM_CLASSES = 6,
    parameter int OUT_TDATA_W = 24
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam logic [CLASS_W:0] NUM_CLASSES_W = (CLASS_W + 1)'(NUM_CLASSES);

    // A stalled result keeps its payload.
    a_hold_stalled_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or vanished");

    // Coming out of reset the result queue is empty.
    a_empty_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_axis_tvalid)
        else $error("result pending right after reset");

    // Every predicted class names a real centroid.
    a_pred_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> {1'b0, m_axis_tdata[CLASS_W-1:0]} < NUM_CLASSES_W)
        else $error("predicted class out of range");

    // Requests are refused only when enough results are already queued,
    // which means one is on offer.
    a_refuse_only_when_backed_up: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid)
        else $error("request refused with no result waiting");

endmodule

bind nearest_centroid_confusion_counter_core ncc_checker #(
    .NUM_CLASSES (NUM_CLASSES),
    .OUT_TDATA_W (OUT_TDATA_W)
) u_ncc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
